// ----- design/assert_macros.svh -----
// Assertion macros shared by the window mean block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define WMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define WMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wmt_pkg.sv -----
// Shared types and constants for the window mean / trimmed mean block.
// No dependencies; used by wmt_div, wmt_store and the top level.
package wmt_pkg;

    localparam int SAMPLE_W       = 17;
    localparam int SIZE_W         = 7;
    // 127 samples of magnitude 65535 fit in 24 signed bits
    localparam int SUM_W          = 24;
    localparam int DIV_CNT_W      = $clog2(SUM_W + 1);
    localparam int DEF_MAX_WINDOW = 64;
    localparam int TRIM_MIN_SIZE  = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic        [SIZE_W-1:0]   t_size;

    localparam t_size   WS_RESET   = 7'd8;
    localparam t_sample SAMPLE_MIN = -17'sd65535;
    localparam logic    KIND_CLEAR = 1'b1;

    // divider request and response
    typedef struct packed {
        logic  start;
        t_sum  dividend;
        t_size divisor;
    } t_div_req;

    typedef struct packed {
        logic    done;
        t_sample quotient;
    } t_div_rsp;

endpackage

// ----- design/wmt_div.sv -----
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on wmt_pkg; quotient truncates toward zero.
module wmt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wmt_pkg::t_div_req i_req,
    output wmt_pkg::t_div_rsp o_rsp
);

    localparam int SUM_W  = wmt_pkg::SUM_W;
    localparam int SIZE_W = wmt_pkg::SIZE_W;
    localparam int CNT_W  = wmt_pkg::DIV_CNT_W;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_dsr;
    logic                 r_neg;

    logic [SUM_W-1:0]     dvd_mag;
    logic [SIZE_W:0]      shifted;
    logic                 fits;
    logic [SIZE_W:0]      diff;
    logic [SUM_W-1:0]     quo_signed;

    // magnitude of the dividend
    assign dvd_mag = i_req.dividend[SUM_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;

    // one restoring step
    assign shifted = {r_rem, r_quo[SUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_dsr});
    assign diff    = shifted - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= dvd_mag;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_neg <= i_req.dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign quo_signed     = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = quo_signed[wmt_pkg::SAMPLE_W-1:0];

endmodule

// ----- design/wmt_store.sv -----
// Sample window store: one write port, one read port with registered data.
// Depends on wmt_pkg for the sample type.
module wmt_store #(
    parameter int DEPTH = wmt_pkg::DEF_MAX_WINDOW,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  wmt_pkg::t_sample i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output wmt_pkg::t_sample o_rd_data
);

    wmt_pkg::t_sample mem [DEPTH];
    wmt_pkg::t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/window_mean_trimmed_minmax.sv -----
// Moving-window statistics: sample store, sequencer, and output register.
// Depends on wmt_pkg, wmt_store, wmt_div and assert_macros.svh.
//
// Each word either adds a sample to a circular window or clears the window;
// one result word follows each input word with the ready flag, window mean,
// trimmed mean (one minimum and one maximum left out), minimum and maximum.
// An add writes the store on acceptance for an effective window size S, scans
// the S entries through the single store read port, runs the two divisions in
// the shared bit-serial divider and then loads the output register (only one
// division when S is below 3). A clear adds a sweep that zeroes all MAX_WINDOW
// entries of the store through its write port, and the same sweep runs after
// reset, during which no word is accepted. A finished result waits in the
// output register while the next word is taken in.
module window_mean_trimmed_minmax #(
    parameter int MAX_WINDOW = wmt_pkg::DEF_MAX_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [wmt_pkg::SIZE_W-1:0]        i_cfg_wr_data,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic signed [wmt_pkg::SAMPLE_W-1:0] i_sample,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ready_res,
    output logic signed [wmt_pkg::SAMPLE_W-1:0] o_mean,
    output logic signed [wmt_pkg::SAMPLE_W-1:0] o_trimmed_mean,
    output logic signed [wmt_pkg::SAMPLE_W-1:0] o_window_min,
    output logic signed [wmt_pkg::SAMPLE_W-1:0] o_window_max
);

`include "assert_macros.svh"

    localparam int SAMPLE_W = wmt_pkg::SAMPLE_W;
    localparam int SIZE_W   = wmt_pkg::SIZE_W;
    localparam int SUM_W    = wmt_pkg::SUM_W;
    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int CW       = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int EFF_CAP  = (MAX_WINDOW < SIZE_MAX) ? MAX_WINDOW : SIZE_MAX;
    localparam logic [AW-1:0]     LAST_ADDR = AW'(MAX_WINDOW - 1);
    localparam wmt_pkg::t_size    CAP_SIZE  = SIZE_W'(EFF_CAP);
    localparam wmt_pkg::t_size    TRIM_MIN  = SIZE_W'(wmt_pkg::TRIM_MIN_SIZE);

    // sequencer states
    localparam logic [2:0] ST_SWEEP    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_DIV_MEAN = 3'd3;
    localparam logic [2:0] ST_DIV_TRIM = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0]        r_state;
    wmt_pkg::t_size    r_ws;
    wmt_pkg::t_size    r_size;
    wmt_pkg::t_size    r_count;
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_item;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic              r_first;
    wmt_pkg::t_sum     r_total;
    wmt_pkg::t_sample  r_lo;
    wmt_pkg::t_sample  r_hi;
    wmt_pkg::t_sample  r_mean;
    wmt_pkg::t_sample  r_trim;
    logic              r_out_valid;
    logic              r_out_ready;
    wmt_pkg::t_sample  r_out_mean;
    wmt_pkg::t_sample  r_out_trim;
    wmt_pkg::t_sample  r_out_min;
    wmt_pkg::t_sample  r_out_max;

    wmt_pkg::t_size    eff_size;
    logic              accept;
    logic              is_clear;
    logic [CW-1:0]     eff_ext;
    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     wp0;
    logic [CW-1:0]     wp1;
    logic [AW-1:0]     n_wp;
    wmt_pkg::t_sample  sample_sat;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    wmt_pkg::t_sample  wr_data;
    logic              rd_issue;
    wmt_pkg::t_sample  rd_data;
    logic              scan_end;
    logic              out_free;
    wmt_pkg::t_sum     trim_dvd;
    wmt_pkg::t_div_req div_req;
    wmt_pkg::t_div_rsp div_rsp;

    // effective window size from the register
    always_comb begin
        if (r_ws == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_ws > CAP_SIZE) begin
            eff_size = CAP_SIZE;
        end else begin
            eff_size = r_ws;
        end
    end

    assign accept   = i_valid && !o_stall;
    assign is_clear = (i_kind == wmt_pkg::KIND_CLEAR);
    assign o_stall  = (r_state != ST_IDLE);

    // write position wraps before and after the write
    assign eff_ext  = CW'(eff_size);
    assign size_ext = CW'(r_size);
    assign wp0      = (CW'(r_wp) >= eff_ext) ? '0 : CW'(r_wp);
    assign wp1      = wp0 + 1'b1;
    assign n_wp     = (wp1 >= eff_ext) ? '0 : wp1[AW-1:0];

    // the one pattern below the range saturates
    assign sample_sat = (i_sample < wmt_pkg::SAMPLE_MIN) ? wmt_pkg::SAMPLE_MIN : i_sample;

    // store write port: clearing sweep or sample write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        if (r_state == ST_SWEEP) begin
            wr_en = 1'b1;
        end else if (accept && !is_clear) begin
            wr_en   = 1'b1;
            wr_addr = wp0[AW-1:0];
            wr_data = sample_sat;
        end
    end

    // scan reads entries 0 .. size-1, data arrives on the next cycle
    assign rd_issue = (r_state == ST_SCAN) && (r_idx < size_ext);
    assign scan_end = (r_state == ST_SCAN) && !rd_issue && !r_pend;

    wmt_store #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // divider requests: mean after the scan, trimmed mean after the mean
    assign trim_dvd = r_total - {{(SUM_W-SAMPLE_W){r_lo[SAMPLE_W-1]}}, r_lo}
                              - {{(SUM_W-SAMPLE_W){r_hi[SAMPLE_W-1]}}, r_hi};

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_total;
        div_req.divisor  = r_size;
        if (scan_end) begin
            div_req.start = 1'b1;
        end else if (r_state == ST_DIV_MEAN) begin
            div_req.dividend = trim_dvd;
            div_req.divisor  = r_size - SIZE_W'(2);
            div_req.start    = div_rsp.done && (r_size >= TRIM_MIN);
        end
    end

    wmt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || !i_stall;

    // sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_ws        <= wmt_pkg::WS_RESET;
            r_size      <= SIZE_W'(1);
            r_count     <= '0;
            r_wp        <= '0;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ws <= i_cfg_wr_data;
            end
            r_pend <= rd_issue;
            // output word: load a finished result or retire a delivered one
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SWEEP: begin
                    if (r_clr_addr == LAST_ADDR) begin
                        r_clr_addr <= '0;
                        r_idx      <= '0;
                        r_state    <= r_clr_item ? ST_SCAN : ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_size <= eff_size;
                        r_idx  <= '0;
                        if (is_clear) begin
                            r_wp       <= '0;
                            r_count    <= '0;
                            r_clr_item <= 1'b1;
                            r_state    <= ST_SWEEP;
                        end else begin
                            r_wp <= n_wp;
                            if (r_count < eff_size) begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (rd_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= ST_DIV_MEAN;
                    end
                end
                ST_DIV_MEAN: begin
                    if (div_rsp.done) begin
                        r_state <= (r_size >= TRIM_MIN) ? ST_DIV_TRIM : ST_DONE;
                    end
                end
                ST_DIV_TRIM: begin
                    if (div_rsp.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_clr_item  <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_SWEEP;
                end
            endcase
        end
    end

    // scan accumulation: total, minimum, maximum
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE || r_state == ST_SWEEP) begin
            r_first <= 1'b1;
            r_total <= '0;
        end else if (r_pend) begin
            r_first <= 1'b0;
            r_total <= r_total + {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
            r_lo    <= (r_first || rd_data < r_lo) ? rd_data : r_lo;
            r_hi    <= (r_first || rd_data > r_hi) ? rd_data : r_hi;
        end
    end

    // quotients and output word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV_MEAN && div_rsp.done) begin
            r_mean <= div_rsp.quotient;
            r_trim <= '0;
        end
        if (r_state == ST_DIV_TRIM && div_rsp.done) begin
            r_trim <= div_rsp.quotient;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_ready <= (r_count >= r_size);
            r_out_mean  <= r_mean;
            r_out_trim  <= r_trim;
            r_out_min   <= r_lo;
            r_out_max   <= r_hi;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ready_res    = r_out_ready;
    assign o_mean         = r_out_mean;
    assign o_trimmed_mean = r_out_trim;
    assign o_window_min   = r_out_min;
    assign o_window_max   = r_out_max;

    // checks
    `WMT_ASSERT_NEXT(a_hold_result, (r_state == ST_DONE) && r_out_valid && i_stall, (r_state == ST_DONE), "result loaded over an undelivered word")
    `WMT_ASSERT_NEXT(a_accept_busy, accept, (r_state != ST_IDLE), "accepted word did not start work")
    `WMT_ASSERT_NOW(a_wp_in_window, (r_state == ST_SCAN), (CW'(r_wp) < size_ext), "write position outside the window")
    `WMT_ASSERT_NOW(a_div_done_state, div_rsp.done, (r_state == ST_DIV_MEAN) || (r_state == ST_DIV_TRIM), "divider finished outside a division step")

endmodule

// ----- dv/window_mean_trimmed_minmax_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for window_mean_trimmed_minmax: directed and random words,
// random idling on both channels, a scoreboard class that predicts every result word.
// Depends on wmt_pkg and the window_mean_trimmed_minmax top level.

localparam logic KIND_ADD  = 1'b0;
localparam int   WIN_DEPTH = wmt_pkg::DEF_MAX_WINDOW;

typedef struct packed {
    logic             ready;
    wmt_pkg::t_sample mean;
    wmt_pkg::t_sample trimmed;
    wmt_pkg::t_sample lo;
    wmt_pkg::t_sample hi;
} t_window_stats;

// Tracks the window store, predicts the stats word for each accepted word,
// and checks result words in order.
class t_stats_board;
    int             store[WIN_DEPTH];
    int unsigned    wr_pos;
    int unsigned    fill;
    wmt_pkg::t_size size_reg;
    t_window_stats  exp_q[$];
    int unsigned    n_checked;
    int unsigned    n_bad;

    function new();
        foreach (store[i]) store[i] = 0;
        wr_pos    = 0;
        fill      = 0;
        size_reg  = wmt_pkg::WS_RESET;
        n_checked = 0;
        n_bad     = 0;
    endfunction

    // register value clamped to 1..WIN_DEPTH
    function int unsigned span();
        if (size_reg == 0) return 1;
        if (size_reg > WIN_DEPTH) return WIN_DEPTH;
        return size_reg;
    endfunction

    function void set_size(wmt_pkg::t_size v);
        size_reg = v;
    endfunction

    function void note_word(logic kind, wmt_pkg::t_sample raw);
        int unsigned   n;
        int unsigned   i;
        int            v;
        int            lo;
        int            hi;
        longint        total;
        t_window_stats e;
        n = span();
        if (kind == wmt_pkg::KIND_CLEAR) begin
            foreach (store[k]) store[k] = 0;
            wr_pos = 0;
            fill   = 0;
        end else begin
            v = raw;
            if (v < wmt_pkg::SAMPLE_MIN) v = wmt_pkg::SAMPLE_MIN;
            // position may sit past a window that just shrank
            if (wr_pos >= n) wr_pos = 0;
            store[wr_pos] = v;
            wr_pos++;
            if (wr_pos >= n) wr_pos = 0;
            if (fill < n) fill++;
        end
        total = 0;
        lo    = store[0];
        hi    = store[0];
        for (i = 0; i < n; i++) begin
            total += store[i];
            if (store[i] < lo) lo = store[i];
            if (store[i] > hi) hi = store[i];
        end
        e.ready = (fill >= n);
        e.mean  = wmt_pkg::t_sample'(total / longint'(n));
        if (n >= wmt_pkg::TRIM_MIN_SIZE)
            e.trimmed = wmt_pkg::t_sample'((total - lo - hi) / (longint'(n) - 2));
        else
            e.trimmed = '0;
        e.lo = wmt_pkg::t_sample'(lo);
        e.hi = wmt_pkg::t_sample'(hi);
        exp_q.push_back(e);
    endfunction

    function void check_result(logic ready, wmt_pkg::t_sample mean,
                               wmt_pkg::t_sample trimmed,
                               wmt_pkg::t_sample lo, wmt_pkg::t_sample hi);
        t_window_stats e;
        if (exp_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("unexpected result word: ready=%0d mean=%0d trim=%0d min=%0d max=%0d",
                         ready, mean, trimmed, lo, hi);
            return;
        end
        e = exp_q.pop_front();
        n_checked++;
        if (ready !== e.ready || mean !== e.mean || trimmed !== e.trimmed ||
            lo !== e.lo || hi !== e.hi) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("mismatch on result %0d:", n_checked);
                $display("  exp ready=%0d mean=%0d trim=%0d min=%0d max=%0d",
                         e.ready, e.mean, e.trimmed, e.lo, e.hi);
                $display("  got ready=%0d mean=%0d trim=%0d min=%0d max=%0d",
                         ready, mean, trimmed, lo, hi);
            end
        end
    endfunction
endclass

module window_mean_trimmed_minmax_tb;

    localparam int ITEMS_TARGET = 1250;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 250;
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    wmt_pkg::t_size   i_cfg_wr_data;
    logic             i_valid;
    logic             o_stall;
    logic             i_kind;
    wmt_pkg::t_sample i_sample;
    logic             o_valid;
    logic             i_stall;
    logic             o_ready_res;
    wmt_pkg::t_sample o_mean;
    wmt_pkg::t_sample o_trimmed_mean;
    wmt_pkg::t_sample o_window_min;
    wmt_pkg::t_sample o_window_max;

    t_stats_board board = new();

    bit          sender_idles    = 1'b0;
    bit          receiver_stalls = 1'b0;
    bit          hold_req        = 1'b0;
    int unsigned cycle_cnt       = 0;
    int unsigned n_sent          = 0;
    int unsigned n_clears        = 0;
    int unsigned n_settings      = 0;

    window_mean_trimmed_minmax DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_ready_res    (o_ready_res),
        .o_mean         (o_mean),
        .o_trimmed_mean (o_trimmed_mean),
        .o_window_min   (o_window_min),
        .o_window_max   (o_window_max)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, board.exp_q.size());
        $display("window_mean_trimmed_minmax_tb: done, errors");
        $finish;
    end

    // result side: check every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_ready_res, o_mean, o_trimmed_mean,
                               o_window_min, o_window_max);
    end

    // result side stall: one long hold on request, otherwise random bursts
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // offer one word, hold it until taken, then maybe idle a burst
    task automatic send_word(input logic kind, input wmt_pkg::t_sample s);
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        board.note_word(kind, s);
        n_sent++;
        if (kind == wmt_pkg::KIND_CLEAR) n_clears++;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every predicted word to come back
    task automatic drain();
        i_valid <= 1'b0;
        while (board.exp_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_window(input wmt_pkg::t_size v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        board.set_size(v);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // extremes, the saturating pattern, small values and full-width noise
    function automatic wmt_pkg::t_sample rand_sample();
        case ($urandom_range(0, 9))
            0:       return 17'sd65535;
            1:       return wmt_pkg::SAMPLE_MIN;
            2:       return wmt_pkg::t_sample'(17'h10000);
            3:       return '0;
            4, 5:    return wmt_pkg::t_sample'(int'($urandom_range(0, 200)) - 100);
            default: return wmt_pkg::t_sample'($urandom());
        endcase
    endfunction

    // mostly short windows; the out-of-range codes and the full depth now and then
    function automatic wmt_pkg::t_size rand_size();
        case ($urandom_range(0, 11))
            0:       return wmt_pkg::t_size'(0);
            1:       return wmt_pkg::t_size'(1);
            2:       return wmt_pkg::t_size'(2);
            3:       return wmt_pkg::t_size'(3);
            4:       return wmt_pkg::t_size'(WIN_DEPTH);
            5:       return wmt_pkg::t_size'($urandom_range(WIN_DEPTH + 1, 127));
            default: return wmt_pkg::t_size'($urandom_range(4, 16));
        endcase
    endfunction

    initial begin
        int unsigned len;
        bit          quiet;
        bit          hold_done;
        hold_done     = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_ADD;
        i_sample      <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset window of 8, extremes and saturation, then a clear
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        send_word(KIND_ADD, 17'sd65535);
        send_word(KIND_ADD, wmt_pkg::SAMPLE_MIN);
        send_word(KIND_ADD, wmt_pkg::t_sample'(17'h10000));
        send_word(KIND_ADD, 17'sd0);
        send_word(KIND_ADD, 17'sd1);
        send_word(KIND_ADD, -17'sd1);
        send_word(KIND_ADD, 17'sd65535);
        send_word(KIND_ADD, wmt_pkg::SAMPLE_MIN);
        send_word(wmt_pkg::KIND_CLEAR, wmt_pkg::t_sample'(17'h1FFFF));
        send_word(KIND_ADD, 17'sd12345);
        // register above the depth acts as the full depth
        set_window(wmt_pkg::t_size'(127));
        send_word(KIND_ADD, -17'sd7);
        send_word(KIND_ADD, 17'sd65535);
        send_word(KIND_ADD, 17'sd3);
        // zero acts as one; write position wraps, kept count reads ready
        set_window(wmt_pkg::t_size'(0));
        send_word(KIND_ADD, wmt_pkg::t_sample'(17'h10000));
        send_word(KIND_ADD, 17'sd500);
        // below three the trimmed mean is zero
        set_window(wmt_pkg::t_size'(2));
        send_word(KIND_ADD, 17'sd9);
        send_word(KIND_ADD, -17'sd9);
        set_window(wmt_pkg::t_size'(3));
        send_word(KIND_ADD, 17'sd65535);
        send_word(KIND_ADD, wmt_pkg::SAMPLE_MIN);
        send_word(KIND_ADD, 17'sd2);
        // grow again: entries outside the old window come back into use
        set_window(wmt_pkg::t_size'(WIN_DEPTH + 1));
        send_word(KIND_ADD, 17'sd1);
        // clear must zero the whole depth
        send_word(wmt_pkg::KIND_CLEAR, '0);
        set_window(wmt_pkg::t_size'(WIN_DEPTH));
        send_word(KIND_ADD, 17'sd100);

        // random phases, one window setting each, no idling in the tail
        while (n_sent < ITEMS_TARGET) begin
            quiet = (n_sent + QUIET_TAIL >= ITEMS_TARGET);
            set_window(rand_size());
            sender_idles    = !quiet && ($urandom_range(0, 2) != 0);
            receiver_stalls = !quiet && ($urandom_range(0, 2) != 0);
            if (!hold_done && n_sent > 300) begin
                // back-pressure: result side holds while words keep coming
                hold_done    = 1'b1;
                sender_idles = 1'b0;
                hold_req     = 1'b1;
            end
            len = $urandom_range(20, 80);
            repeat (len) begin
                if ($urandom_range(0, 24) == 0)
                    send_word(wmt_pkg::KIND_CLEAR, wmt_pkg::t_sample'($urandom()));
                else
                    send_word(KIND_ADD, rand_sample());
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d words (%0d clears) over %0d window settings in %0d cycles",
                 n_sent, n_clears, n_settings, cycle_cnt);
        $display("checked %0d result words, %0d mismatches, %0d still expected",
                 board.n_checked, board.n_bad, board.exp_q.size());
        if (board.n_bad == 0 && board.exp_q.size() == 0)
            $display("window_mean_trimmed_minmax_tb: done, clean");
        else
            $display("window_mean_trimmed_minmax_tb: done, errors");
        $finish;
    end

endmodule
